FILE: rtl/qpd_pkg.sv
// Shared types, constants and helper functions for the quoted-printable decoder.
`timescale 1ns / 1ps

package qpd_pkg;

    // Output cap per body (at most MAX_OUT-1 bytes are emitted)
    localparam int          MAX_OUT   = 32768;
    localparam int          CNT_W     = 16;
    localparam logic [15:0] OUT_CAP   = 16'(MAX_OUT - 1);

    // Results per input item
    localparam int          GRP_BYTES = 4;

    // Group queue geometry
    localparam int          QAW       = 2;
    localparam int          QDEPTH    = 1 << QAW;

    // Configuration port
    localparam int          PADDR_W   = 3;
    localparam logic        REG_DECODE_ENABLE = 1'b0;

    // Character codes
    localparam logic [7:0]  CH_EQ     = 8'h3D;
    localparam logic [7:0]  CH_CR     = 8'h0D;
    localparam logic [7:0]  CH_LF     = 8'h0A;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_EQ     = 2'd1,
        MODE_EQ_HEX = 2'd2,
        MODE_EQ_CR  = 2'd3
    } t_qpd_mode;

    typedef struct packed {
        logic [7:0] body_byte;
        logic       body_last;
    } t_qpd_in;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       run_last;
        logic       body_done;
    } t_qpd_out;

    // One input item's worth of results, as held in the queue
    typedef struct packed {
        logic [GRP_BYTES-1:0][7:0] bytes;
        logic [1:0]                cnt_m1;
        logic                      bare;
        logic                      last;
    } t_qpd_grp;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qpd_qstat;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h37;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h57;
        end
        return v[3:0];
    endfunction

endpackage

FILE: rtl/qpd_front.sv
// Front end: accepts body bytes, tracks escape sequences and builds result groups.
`timescale 1ns / 1ps

module qpd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_decode_enable,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  qpd_pkg::t_qpd_in  i_in_data,
    input  qpd_pkg::t_qpd_qstat i_qstat,
    output logic              o_push,
    output qpd_pkg::t_qpd_grp o_push_rec
);

    qpd_pkg::t_qpd_mode r_mode, n_mode;
    logic [7:0]         r_held, n_held;
    logic [15:0]        r_count, n_count;

    qpd_pkg::t_qpd_mode w_mid_mode;
    logic [7:0]         w_mid_held;
    logic               w_feed;
    logic               w_starts_seq;
    logic               w_accept;
    logic [7:0]         w_b;
    logic               w_last;
    logic               w_b_hex;
    logic [qpd_pkg::GRP_BYTES-1:0][7:0] w_cand;
    logic [2:0]         w_cand_n;
    logic [15:0]        w_room;
    logic [2:0]         w_n;

    assign w_b        = i_in_data.body_byte;
    assign w_last     = i_in_data.body_last;
    assign w_b_hex    = qpd_pkg::is_hex(w_b);
    assign o_in_ready = !i_qstat.full;
    assign w_accept   = i_in_valid && o_in_ready;

    // Classify the byte against the pending sequence
    always_comb begin
        w_feed     = 1'b0;
        w_mid_mode = r_mode;
        w_mid_held = r_held;
        case (r_mode)
            qpd_pkg::MODE_IDLE: begin
                w_feed = 1'b1;
            end
            qpd_pkg::MODE_EQ: begin
                if (w_b == qpd_pkg::CH_CR) begin
                    w_mid_mode = qpd_pkg::MODE_EQ_CR;
                end else if (w_b == qpd_pkg::CH_LF) begin
                    w_mid_mode = qpd_pkg::MODE_IDLE;
                end else if (w_b_hex) begin
                    w_mid_held = w_b;
                    w_mid_mode = qpd_pkg::MODE_EQ_HEX;
                end else begin
                    w_mid_mode = qpd_pkg::MODE_IDLE;
                    w_feed     = 1'b1;
                end
            end
            qpd_pkg::MODE_EQ_HEX: begin
                w_mid_mode = qpd_pkg::MODE_IDLE;
                w_feed     = !w_b_hex;
            end
            default: begin
                w_mid_mode = qpd_pkg::MODE_IDLE;
                w_feed     = (w_b != qpd_pkg::CH_LF);
            end
        endcase
        w_starts_seq = w_feed && (w_b == qpd_pkg::CH_EQ) && i_decode_enable;
        if (w_starts_seq) begin
            w_mid_mode = qpd_pkg::MODE_EQ;
        end
    end

    // Next state: end of body returns everything to idle
    always_comb begin
        n_mode  = r_mode;
        n_held  = r_held;
        n_count = r_count;
        if (w_accept) begin
            if (w_last) begin
                n_mode  = qpd_pkg::MODE_IDLE;
                n_held  = 8'h00;
                n_count = '0;
            end else begin
                n_mode  = w_mid_mode;
                n_held  = w_mid_held;
                n_count = r_count + {13'd0, w_n};
            end
        end
    end

    // Outputs: list candidate bytes in emit order, then apply the cap
    always_comb begin
        w_cand   = '0;
        w_cand_n = 3'd0;
        case (r_mode)
            qpd_pkg::MODE_EQ: begin
                if (w_feed) begin
                    w_cand[w_cand_n[1:0]] = qpd_pkg::CH_EQ;
                    w_cand_n = w_cand_n + 3'd1;
                end
            end
            qpd_pkg::MODE_EQ_HEX: begin
                if (w_b_hex) begin
                    w_cand[w_cand_n[1:0]] = {qpd_pkg::hex_val(r_held), qpd_pkg::hex_val(w_b)};
                    w_cand_n = w_cand_n + 3'd1;
                end else begin
                    w_cand[w_cand_n[1:0]] = qpd_pkg::CH_EQ;
                    w_cand_n = w_cand_n + 3'd1;
                    w_cand[w_cand_n[1:0]] = r_held;
                    w_cand_n = w_cand_n + 3'd1;
                end
            end
            default: begin
            end
        endcase
        if (w_feed && !w_starts_seq) begin
            w_cand[w_cand_n[1:0]] = w_b;
            w_cand_n = w_cand_n + 3'd1;
        end
        // Flush a pending sequence at end of body
        if (w_last) begin
            if (w_mid_mode == qpd_pkg::MODE_EQ) begin
                w_cand[w_cand_n[1:0]] = qpd_pkg::CH_EQ;
                w_cand_n = w_cand_n + 3'd1;
            end else if (w_mid_mode == qpd_pkg::MODE_EQ_HEX) begin
                w_cand[w_cand_n[1:0]] = qpd_pkg::CH_EQ;
                w_cand_n = w_cand_n + 3'd1;
                w_cand[w_cand_n[1:0]] = w_mid_held;
                w_cand_n = w_cand_n + 3'd1;
            end
        end
        w_room = qpd_pkg::OUT_CAP - r_count;
        w_n    = (w_room < {13'd0, w_cand_n}) ? w_room[2:0] : w_cand_n;

        o_push_rec.bytes  = w_cand;
        o_push_rec.cnt_m1 = 2'(w_n - 3'd1);
        o_push_rec.bare   = (w_n == 3'd0);
        o_push_rec.last   = w_last;
        o_push            = w_accept && ((w_n != 3'd0) || w_last);
    end

    // Hold sequence state and the body byte count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= qpd_pkg::MODE_IDLE;
            r_held  <= 8'h00;
            r_count <= '0;
        end else begin
            r_mode  <= n_mode;
            r_held  <= n_held;
            r_count <= n_count;
        end
    end

endmodule

FILE: rtl/qpd_queue.sv
// Short queue of result groups between the front end and the output serializer.
`timescale 1ns / 1ps

module qpd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  qpd_pkg::t_qpd_grp   i_push_rec,
    input  logic                i_pop,
    output qpd_pkg::t_qpd_grp   o_head,
    output qpd_pkg::t_qpd_qstat o_qstat
);

    qpd_pkg::t_qpd_grp r_slot [qpd_pkg::QDEPTH];
    logic [qpd_pkg::QAW-1:0] r_wr_ptr, r_rd_ptr;
    logic [qpd_pkg::QAW:0]   r_fill;

    assign o_qstat.full  = (r_fill == (qpd_pkg::QAW + 1)'(qpd_pkg::QDEPTH));
    assign o_qstat.empty = (r_fill == '0);
    assign o_head        = r_slot[r_rd_ptr];

    // Store a pushed group
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_rec;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/qpd_back.sv
// Back end: walks the head group and presents one result per transfer.
`timescale 1ns / 1ps

module qpd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  qpd_pkg::t_qpd_grp   i_head,
    input  qpd_pkg::t_qpd_qstat i_qstat,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output qpd_pkg::t_qpd_out   o_out_data
);

    logic [1:0] r_idx, n_idx;
    logic       w_run_last;
    logic       w_xfer;

    assign o_out_valid = !i_qstat.empty;
    assign w_xfer      = o_out_valid && i_out_ready;
    assign w_run_last  = i_head.bare || (r_idx == i_head.cnt_m1);
    assign o_pop       = w_xfer && w_run_last;

    // Select the current result of the head group
    always_comb begin
        o_out_data.data_byte = i_head.bare ? 8'h00 : i_head.bytes[r_idx];
        o_out_data.has_byte  = !i_head.bare;
        o_out_data.run_last  = w_run_last;
        o_out_data.body_done = w_run_last && i_head.last;
    end

    // Step through the group, restart at the next one
    always_comb begin
        n_idx = r_idx;
        if (w_xfer) begin
            n_idx = w_run_last ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else begin
            r_idx <= n_idx;
        end
    end

endmodule

FILE: rtl/quoted_printable_decoder.sv
// Top level of the quoted-printable decoder: register port, front end, queue, back end.
//
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one body byte per
// transfer; body_last marks the final byte of a body and flushes any pending
// escape. Output channel (o_out_valid / i_out_ready / o_out_data) gives decoded
// bytes, with run_last on the final result of each input byte and body_done
// on the final result of a body; a body whose last byte emits nothing gives a
// bare marker with has_byte low.
// The first result of a byte is offered once its group, held in the queue, is at the head.
// Throughput: one input byte per cycle unless the queue is full; a byte yielding k
// results (up to three) holds the output serializer until all k are transferred, and
// the four-group queue between front end and serializer absorbs such bursts.
// A stalled receiver leaves the current result steady; the front end keeps
// taking bytes until the queue is full, then drops o_in_ready.
// Reset (synchronous, active low) empties the queue, clears the escape state
// and byte count, and sets decode_enable to 1. The APB register decode_enable
// sits at address 0; the user must write it only while the block is idle, as the block does not enforce it.
`timescale 1ns / 1ps

module quoted_printable_decoder (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  qpd_pkg::t_qpd_in               i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output qpd_pkg::t_qpd_out              o_out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [qpd_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    logic                r_decode_enable;
    logic                w_reg_sel;
    logic                w_push;
    logic                w_pop;
    qpd_pkg::t_qpd_grp   w_push_rec;
    qpd_pkg::t_qpd_grp   w_head;
    qpd_pkg::t_qpd_qstat w_qstat;

    // Register decode: byte address 4*i
    assign pready    = 1'b1;
    assign w_reg_sel = (paddr[qpd_pkg::PADDR_W-1:2] == qpd_pkg::REG_DECODE_ENABLE);
    assign prdata    = (psel && w_reg_sel) ? {31'd0, r_decode_enable} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decode_enable <= 1'b1;
        end else if (psel && penable && pwrite && pready && w_reg_sel) begin
            r_decode_enable <= pwdata[0];
        end
    end

    qpd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_decode_enable(r_decode_enable),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_data      (i_in_data),
        .i_qstat        (w_qstat),
        .o_push         (w_push),
        .o_push_rec     (w_push_rec)
    );

    qpd_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .i_push_rec(w_push_rec),
        .i_pop     (w_pop),
        .o_head    (w_head),
        .o_qstat   (w_qstat)
    );

    qpd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .i_qstat    (w_qstat),
        .o_pop      (w_pop),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

endmodule

FILE: rtl/qpd_checker.sv
// Port-level assertions for the quoted-printable decoder, bound to the top level.
`timescale 1ns / 1ps

module qpd_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              o_out_valid,
    input  logic              i_out_ready,
    input  qpd_pkg::t_qpd_out o_out_data
);

    // Hold an offered result until its transfer
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output valid dropped before transfer");

    // Bare marker is an end of body with a zero byte
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.has_byte |->
            o_out_data.run_last && o_out_data.body_done && (o_out_data.data_byte == 8'h00))
        else $error("bare marker without end flags");

    // End of body always closes the current input byte's run
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.body_done |-> o_out_data.run_last)
        else $error("body_done without run_last");

    // Nothing is offered right after reset
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind quoted_printable_decoder qpd_checker u_qpd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_data (o_out_data)
);
